FILE: design/flptw_pkg.sv
// ----------------------------------------------------------------------------
// flptw_pkg: shared types and codes of the page table walker
// Mode and status codes, controller states and the controller/datapath
// command and status groups.
// ----------------------------------------------------------------------------
`default_nettype none
package flptw_pkg;

    localparam logic [1:0] MODE_MAP    = 2'd0;
    localparam logic [1:0] MODE_UNMAP  = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MISALIGN  = 3'd1;
    localparam logic [2:0] ST_ALREADY   = 3'd2;
    localparam logic [2:0] ST_NOT_MAP   = 3'd3;
    localparam logic [2:0] ST_EXHAUSTED = 3'd4;
    localparam logic [2:0] ST_MISS      = 3'd5;

    localparam logic [1:0] LEAF_LEVEL = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_EVAL
    } wk_state_t;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       rd;
        logic       follow;
        logic       alloc;
        logic       leaf_write;
        logic       finish;
        logic [2:0] fin_status;
        logic       lookup_hit;
    } wk_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       misaligned;
        logic       count_zero;
        logic [1:0] level;
        logic       desc_valid;
        logic       desc_in_pool;
        logic       pool_full;
        logic       last_page;
        logic       clr_last;
    } wk_stat_t;

endpackage
`default_nettype wire

FILE: design/flptw_ctrl.sv
// ----------------------------------------------------------------------------
// flptw_ctrl: walk sequencer
// Clears the store after reset, then steps each map or unmap item through
// alignment checks, four descriptor reads per page and the leaf update.
// ----------------------------------------------------------------------------
`default_nettype none
module flptw_ctrl
    import flptw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire wk_stat_t stat,
    output wk_cmd_t       cmd
);

    wk_state_t state_reg, state_next;

    // hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // sequence the walk
    always_comb
    begin
        logic [2:0] absent_code;
        absent_code = (stat.mode == MODE_UNMAP) ? ST_NOT_MAP : ST_MISS;
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.mode == MODE_NONE)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_OK;
                    state_next = S_IDLE;
                end
                else if (stat.mode == MODE_LOOKUP)
                begin
                    state_next = S_READ;
                end
                else if (stat.misaligned)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_MISALIGN;
                    state_next = S_IDLE;
                end
                else if (stat.count_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_status = ST_OK;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.level != LEAF_LEVEL)
                begin
                    // table descriptor: follow, allocate or stop
                    if (stat.desc_valid)
                    begin
                        if (stat.desc_in_pool)
                        begin
                            cmd.follow = 1'b1;
                            state_next = S_READ;
                        end
                        else
                        begin
                            cmd.finish = 1'b1;
                            cmd.fin_status = (stat.mode == MODE_MAP) ? ST_EXHAUSTED
                                                                     : absent_code;
                            state_next = S_IDLE;
                        end
                    end
                    else if (stat.mode != MODE_MAP)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = absent_code;
                        state_next = S_IDLE;
                    end
                    else if (stat.pool_full)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = ST_EXHAUSTED;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.alloc  = 1'b1;
                        state_next = S_READ;
                    end
                end
                else if (stat.mode == MODE_LOOKUP)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = stat.desc_valid ? ST_OK : ST_MISS;
                    cmd.lookup_hit = stat.desc_valid;
                    state_next     = S_IDLE;
                end
                else if (stat.desc_valid == (stat.mode == MODE_MAP))
                begin
                    // map over a live leaf, or unmap of a dead one
                    cmd.finish = 1'b1;
                    cmd.fin_status = (stat.mode == MODE_MAP) ? ST_ALREADY : ST_NOT_MAP;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.leaf_write = 1'b1;
                    if (stat.last_page)
                    begin
                        cmd.finish = 1'b1;
                        cmd.fin_status = ST_OK;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: design/flptw_datapath.sv
// ----------------------------------------------------------------------------
// flptw_datapath: table store and walk registers
// Holds the descriptor memory, the walk position, the table allocator and
// the result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module flptw_datapath
    import flptw_pkg::*;
#(
    parameter int TABLE_PAGES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [35:0] cfg_wdata,
    input  wire logic [1:0]  mode,
    input  wire logic [47:0] virt_addr,
    input  wire logic [47:0] phys_addr,
    input  wire logic [15:0] page_count,
    input  wire logic [1:0]  access_perms,
    input  wire logic [2:0]  attr_slot,
    input  wire logic [1:0]  share_kind,
    input  wire logic        priv_no_exec,
    input  wire logic        user_no_exec,
    input  wire wk_cmd_t     cmd,
    output wk_stat_t         stat,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [47:0]      phys_result,
    output logic [15:0]      pages_done
);

    localparam int TBL_W  = $clog2(TABLE_PAGES);
    localparam int USED_W = $clog2(TABLE_PAGES + 1);
    localparam int ADDR_W = TBL_W + 9;
    localparam int DEPTH  = TABLE_PAGES * 512;

    logic [63:0] mem [DEPTH];
    logic [63:0] q_reg;

    logic [35:0]       pool_base_reg;
    logic [USED_W-1:0] used_reg;
    logic [ADDR_W-1:0] clr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [TBL_W-1:0]  tbl_reg;
    logic [1:0]        level_reg;
    logic              out_valid_reg;

    logic [1:0]  mode_reg;
    logic [47:0] va_reg;
    logic [47:0] pa_reg;
    logic [15:0] count_reg;
    logic [15:0] done_reg;
    logic [7:0]  attr_reg;
    logic [1:0]  xn_reg;
    logic [2:0]  status_reg;
    logic [47:0] phys_reg;
    logic [15:0] pages_reg;

    logic [8:0]        idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [35:0]       rel;
    logic [35:0]       new_pn;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [63:0]       wdata;
    logic [15:0]       done_next;

    // pick the index of the current level
    always_comb
    begin
        case (level_reg)
            2'd0:    idx = va_reg[47:39];
            2'd1:    idx = va_reg[38:30];
            2'd2:    idx = va_reg[29:21];
            default: idx = va_reg[20:12];
        endcase
    end

    assign rd_addr   = {tbl_reg, idx};
    assign rel       = q_reg[47:12] - pool_base_reg;
    assign new_pn    = pool_base_reg + 36'(used_reg);
    assign done_next = done_reg + 16'(cmd.leaf_write);

    // select the write port source
    always_comb
    begin
        we    = cmd.clr | cmd.alloc | cmd.leaf_write;
        waddr = cmd.clr ? clr_reg : addr_reg;
        if (cmd.alloc)
        begin
            wdata = {16'd0, new_pn, 10'd0, 2'b11};
        end
        else if (cmd.leaf_write && mode_reg == MODE_MAP)
        begin
            wdata = {9'd0, xn_reg, 5'd0, pa_reg[47:12], 1'b0, 1'b1, attr_reg, 2'b11};
        end
        else
        begin
            wdata = '0;
        end
    end

    // descriptor memory
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_base_reg <= '0;
            used_reg      <= USED_W'(1);
            clr_reg       <= '0;
            tbl_reg       <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                pool_base_reg <= cfg_wdata;
            end
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + ADDR_W'(1);
            end
            if (cmd.load || cmd.leaf_write)
            begin
                tbl_reg   <= '0;
                level_reg <= '0;
            end
            else if (cmd.follow)
            begin
                tbl_reg   <= rel[TBL_W-1:0];
                level_reg <= level_reg + 2'd1;
            end
            else if (cmd.alloc)
            begin
                tbl_reg   <= used_reg[TBL_W-1:0];
                level_reg <= level_reg + 2'd1;
                used_reg  <= used_reg + USED_W'(1);
            end
            out_valid_reg <= cmd.finish;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            addr_reg <= rd_addr;
        end
        if (cmd.load)
        begin
            mode_reg  <= mode;
            va_reg    <= virt_addr;
            pa_reg    <= phys_addr;
            count_reg <= page_count;
            done_reg  <= '0;
            attr_reg  <= {share_kind, access_perms, 1'b0, attr_slot};
            xn_reg    <= {user_no_exec, priv_no_exec};
        end
        else if (cmd.leaf_write)
        begin
            done_reg <= done_next;
            va_reg   <= va_reg + 48'h1000;
            pa_reg   <= pa_reg + 48'h1000;
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            phys_reg   <= cmd.lookup_hit ? {q_reg[47:12], va_reg[11:0]} : 48'd0;
            pages_reg  <= cmd.lookup_hit ? 16'd1 : done_next;
        end
    end

    // report to the controller
    always_comb
    begin
        stat.mode         = mode_reg;
        stat.misaligned   = (va_reg[11:0] != 12'd0) ||
                            (mode_reg == MODE_MAP && pa_reg[11:0] != 12'd0);
        stat.count_zero   = (count_reg == 16'd0);
        stat.level        = level_reg;
        stat.desc_valid   = q_reg[0];
        stat.desc_in_pool = (rel < 36'(used_reg));
        stat.pool_full    = (used_reg == USED_W'(TABLE_PAGES));
        stat.last_page    = (17'(done_reg) + 17'd1 == 17'(count_reg));
        stat.clr_last     = (clr_reg == ADDR_W'(DEPTH - 1));
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign phys_result  = phys_reg;
    assign pages_done   = pages_reg;

endmodule
`default_nettype wire

FILE: design/four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker: 4 KB granule, four level table walker
// Maps, unmaps and looks up pages in a private pool of translation tables.
// ----------------------------------------------------------------------------
// After reset the block clears its table store of TABLE_PAGES*512 descriptors
// (8192 by default), one descriptor a cycle, with busy high. An item is taken
// when start is high and busy is low. Each page walks four levels: each level
// reads a descriptor, then evaluates it and may write. Busy stays high until
// the item is done. The result shows for one cycle with result_valid and
// cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module four_level_page_table_walker
    import flptw_pkg::*;
#(
    parameter int TABLE_PAGES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [35:0] cfg_wdata,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  mode,
    input  wire logic [47:0] virt_addr,
    input  wire logic [47:0] phys_addr,
    input  wire logic [15:0] page_count,
    input  wire logic [1:0]  access_perms,
    input  wire logic [2:0]  attr_slot,
    input  wire logic [1:0]  share_kind,
    input  wire logic        priv_no_exec,
    input  wire logic        user_no_exec,
    output logic             result_valid,
    output logic [2:0]       status,
    output logic [47:0]      phys_result,
    output logic [15:0]      pages_done
);

    wk_cmd_t  cmd;
    wk_stat_t stat;

    // sequencer
    flptw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // store and registers
    flptw_datapath #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .mode         (mode),
        .virt_addr    (virt_addr),
        .phys_addr    (phys_addr),
        .page_count   (page_count),
        .access_perms (access_perms),
        .attr_slot    (attr_slot),
        .share_kind   (share_kind),
        .priv_no_exec (priv_no_exec),
        .user_no_exec (user_no_exec),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .status       (status),
        .phys_result  (phys_result),
        .pages_done   (pages_done)
    );

endmodule
`default_nettype wire

FILE: tb/tb_four_level_page_table_walker.sv
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker: self-checking bench of the table walker
// A directed table followed by random map, unmap and lookup items over a few
// address regions and several pool base settings. Every result is checked
// against known values for some directed rows, else an in-bench store model.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_four_level_page_table_walker;
    import flptw_pkg::*;

    localparam int NPAGES     = 16;
    localparam int NENT       = 512;
    localparam int CYCLE_CAP  = 30000000;
    localparam int N_RANDOM   = 1800;

    typedef struct {
        logic [1:0]  mode;
        logic [47:0] va;
        logic [47:0] pa;
        logic [15:0] cnt;
        logic [1:0]  ap;
        logic [2:0]  attr;
        logic [1:0]  sh;
        logic        pxn;
        logic        uxn;
    } walk_req_t;

    typedef struct {
        logic [2:0]  status;
        logic [47:0] phys;
        logic [15:0] done;
    } walk_res_t;

    typedef struct {
        walk_req_t req;
        bit        known;
        walk_res_t res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [35:0] cfg_wdata;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [47:0] virt_addr;
    logic [47:0] phys_addr;
    logic [15:0] page_count;
    logic [1:0]  access_perms;
    logic [2:0]  attr_slot;
    logic [1:0]  share_kind;
    logic        priv_no_exec;
    logic        user_no_exec;
    logic        result_valid;
    logic [2:0]  status;
    logic [47:0] phys_result;
    logic [15:0] pages_done;

    // shadow translation state
    logic [63:0] shadow_desc [0:NPAGES*NENT-1];
    int          shadow_used;
    logic [35:0] shadow_base;

    walk_res_t   pending_results[$];
    int          error_count = 0;
    int          items_sent;
    int          results_seen = 0;
    int          cycle_count = 0;

    four_level_page_table_walker #(.TABLE_PAGES(NPAGES)) DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .mode(mode), .virt_addr(virt_addr),
        .phys_addr(phys_addr), .page_count(page_count),
        .access_perms(access_perms), .attr_slot(attr_slot),
        .share_kind(share_kind), .priv_no_exec(priv_no_exec),
        .user_no_exec(user_no_exec), .result_valid(result_valid),
        .status(status), .phys_result(phys_result), .pages_done(pages_done)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want,
                 results_seen);
        error_count++;
    endtask

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        walk_res_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", {61'd0, status}, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", {61'd0, status}, {61'd0, want.status});
                if (phys_result !== want.phys)
                    report_mismatch("phys_result", {16'd0, phys_result},
                                    {16'd0, want.phys});
                if (pages_done !== want.done)
                    report_mismatch("pages_done", {48'd0, pages_done},
                                    {48'd0, want.done});
            end
            results_seen++;
        end
    end

    // follow one table descriptor, allocating when asked; 0 ok, 1 absent, 2 full
    function automatic int follow_desc(input int tbl, input logic [8:0] idx,
                                       input bit alloc, output int next_tbl);
        int          pos;
        logic [35:0] rel;
        pos = tbl * NENT + idx;
        next_tbl = 0;
        if (shadow_desc[pos][0])
        begin
            rel = shadow_desc[pos][47:12] - shadow_base;
            if (rel < shadow_used)
            begin
                next_tbl = int'(rel);
                return 0;
            end
            return alloc ? 2 : 1;
        end
        if (!alloc)
            return 1;
        if (shadow_used >= NPAGES)
            return 2;
        next_tbl = shadow_used;
        shadow_used++;
        shadow_desc[pos] = {16'd0, shadow_base + 36'(next_tbl), 12'h003};
        return 0;
    endfunction

    // walk three table levels to the leaf position
    function automatic int walk_to_leaf(input logic [47:0] va, input bit alloc,
                                        output int leaf);
        int t;
        int r;
        t = 0;
        leaf = 0;
        r = follow_desc(t, va[47:39], alloc, t);
        if (r != 0) return r;
        r = follow_desc(t, va[38:30], alloc, t);
        if (r != 0) return r;
        r = follow_desc(t, va[29:21], alloc, t);
        if (r != 0) return r;
        leaf = t * NENT + va[20:12];
        return 0;
    endfunction

    // apply one item to the shadow state and give its result
    function automatic walk_res_t predict_walk(input walk_req_t q);
        walk_res_t   o;
        logic [47:0] va;
        logic [47:0] pa;
        logic [63:0] attrs;
        int          leaf;
        va = q.va;
        pa = q.pa;
        o.status = ST_OK;
        o.phys = '0;
        o.done = '0;
        case (q.mode)
            MODE_MAP:
            begin
                if (va[11:0] != 0 || pa[11:0] != 0)
                    o.status = ST_MISALIGN;
                else
                begin
                    attrs = 64'h403;
                    attrs[4:2] = q.attr;
                    attrs[7:6] = q.ap;
                    attrs[9:8] = q.sh;
                    attrs[53] = q.pxn;
                    attrs[54] = q.uxn;
                    while (o.done < q.cnt)
                    begin
                        if (walk_to_leaf(va, 1'b1, leaf) != 0)
                        begin
                            o.status = ST_EXHAUSTED;
                            break;
                        end
                        if (shadow_desc[leaf][0])
                        begin
                            o.status = ST_ALREADY;
                            break;
                        end
                        shadow_desc[leaf] = attrs | {16'd0, pa[47:12], 12'd0};
                        o.done++;
                        va = va + 48'h1000;
                        pa = pa + 48'h1000;
                    end
                end
            end
            MODE_UNMAP:
            begin
                if (va[11:0] != 0)
                    o.status = ST_MISALIGN;
                else
                begin
                    while (o.done < q.cnt)
                    begin
                        if (walk_to_leaf(va, 1'b0, leaf) != 0 || !shadow_desc[leaf][0])
                        begin
                            o.status = ST_NOT_MAP;
                            break;
                        end
                        shadow_desc[leaf] = '0;
                        o.done++;
                        va = va + 48'h1000;
                    end
                end
            end
            MODE_LOOKUP:
            begin
                if (walk_to_leaf(va, 1'b0, leaf) != 0 || !shadow_desc[leaf][0])
                    o.status = ST_MISS;
                else
                begin
                    o.phys = {shadow_desc[leaf][47:12], va[11:0]};
                    o.done = 16'd1;
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic walk_req_t make_req(input logic [1:0] m, input logic [47:0] va,
                                           input logic [47:0] pa, input logic [15:0] cnt,
                                           input logic [1:0] ap, input logic [2:0] attr,
                                           input logic [1:0] sh, input logic pxn,
                                           input logic uxn);
        walk_req_t q;
        q.mode = m; q.va = va; q.pa = pa; q.cnt = cnt;
        q.ap = ap; q.attr = attr; q.sh = sh; q.pxn = pxn; q.uxn = uxn;
        return q;
    endfunction

    function automatic walk_res_t make_res(input logic [2:0] s, input logic [47:0] p,
                                           input logic [15:0] d);
        walk_res_t o;
        o.status = s; o.phys = p; o.done = d;
        return o;
    endfunction

    // pick a page inside a few regions so walks share tables
    function automatic logic [47:0] pick_page();
        logic [8:0] l0;
        logic [8:0] l1;
        logic [8:0] l2;
        logic [8:0] l3;
        case ($urandom_range(0, 3))
            0: l0 = 9'd0;
            1: l0 = 9'd1;
            2: l0 = 9'd256;
            default: l0 = 9'd511;
        endcase
        case ($urandom_range(0, 2))
            0: l1 = 9'd0;
            1: l1 = 9'd3;
            default: l1 = 9'd511;
        endcase
        l2 = ($urandom_range(0, 3) == 0) ? 9'd1 : 9'd0;
        l3 = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511))
                                         : 9'($urandom_range(0, 15));
        return {l0, l1, l2, l3, 12'd0};
    endfunction

    function automatic walk_req_t random_req();
        walk_req_t  q;
        int         sel;
        q.mode = MODE_MAP;
        q.va   = pick_page();
        q.pa   = 48'({$urandom(), $urandom()}) & 48'hFFFF_FFFF_F000;
        q.cnt  = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(0, 600))
                                              : 16'($urandom_range(1, 8));
        q.ap   = 2'($urandom());
        q.attr = 3'($urandom());
        q.sh   = 2'($urandom());
        q.pxn  = 1'($urandom());
        q.uxn  = 1'($urandom());
        sel = $urandom_range(0, 99);
        if (sel < 35)
            q.mode = MODE_MAP;
        else if (sel < 55)
            q.mode = MODE_UNMAP;
        else if (sel < 90)
        begin
            q.mode = MODE_LOOKUP;
            q.va[11:0] = 12'($urandom());
        end
        else if (sel < 94)
            q.mode = MODE_NONE;
        else
        begin
            // noise: full-range, mostly misaligned addresses
            q.mode = ($urandom_range(0, 1) == 0) ? MODE_MAP : MODE_UNMAP;
            q.va = 48'({$urandom(), $urandom()});
            q.pa = 48'({$urandom(), $urandom()});
            q.cnt = 16'($urandom());
            if (q.va[11:0] == 0 && q.pa[11:0] == 0)
                q.cnt = 16'($urandom_range(0, 4));
        end
        return q;
    endfunction

    // present one item, hold it until taken, then sometimes idle for a random gap
    task automatic send_item(input walk_req_t q, input bit known, input walk_res_t want);
        walk_res_t got;
        int        gap;
        int        pick;
        start        <= 1'b1;
        mode         <= q.mode;
        virt_addr    <= q.va;
        phys_addr    <= q.pa;
        page_count   <= q.cnt;
        access_perms <= q.ap;
        attr_slot    <= q.attr;
        share_kind   <= q.sh;
        priv_no_exec <= q.pxn;
        user_no_exec <= q.uxn;
        do
            @(posedge clk);
        while (busy);
        got = predict_walk(q);
        pending_results.push_back(known ? want : got);
        items_sent++;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain all results, then write the pool base while idle
    task automatic set_pool_base(input logic [35:0] value);
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_base = value;
    endtask

    initial
    begin
        dir_row_t  rows[$];
        dir_row_t  r;
        walk_res_t none;
        int        i;

        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_wdata = '0; start = 1'b0;
        mode = '0; virt_addr = '0; phys_addr = '0; page_count = '0;
        access_perms = '0; attr_slot = '0; share_kind = '0;
        priv_no_exec = 1'b0; user_no_exec = 1'b0;
        items_sent = 0;
        for (i = 0; i < NPAGES * NENT; i++)
            shadow_desc[i] = '0;
        shadow_used = 1;
        shadow_base = '0;
        none = make_res(ST_OK, '0, '0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows: known results where obvious, otherwise the model
        r.known = 1;
        r.req = make_req(MODE_LOOKUP, 48'h0, 48'h0, 16'd1, 0, 0, 0, 0, 0);
        r.res = make_res(ST_MISS, '0, '0); rows.push_back(r);
        r.req = make_req(MODE_MAP, 48'h1000, 48'h1001, 16'd1, 0, 0, 0, 0, 0);
        r.res = make_res(ST_MISALIGN, '0, '0); rows.push_back(r);
        r.req = make_req(MODE_MAP, 48'h1001, 48'h0, 16'd1, 3, 7, 3, 1, 1);
        r.res = make_res(ST_MISALIGN, '0, '0); rows.push_back(r);
        r.req = make_req(MODE_UNMAP, 48'hFFFF_FFFF_FFFF, 48'h0, 16'hFFFF, 0, 0, 0, 0, 0);
        r.res = make_res(ST_MISALIGN, '0, '0); rows.push_back(r);
        r.req = make_req(MODE_MAP, 48'h5000, 48'h5000, 16'd0, 0, 0, 0, 0, 0);
        r.res = none; rows.push_back(r);
        r.req = make_req(MODE_NONE, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                         3, 7, 3, 1, 1);
        r.res = none; rows.push_back(r);
        r.req = make_req(MODE_MAP, 48'h0, 48'h0, 16'd4, 0, 0, 0, 0, 0);
        r.res = make_res(ST_OK, '0, 16'd4); rows.push_back(r);
        r.req = make_req(MODE_MAP, 48'h0, 48'h9000, 16'd1, 0, 0, 0, 0, 0);
        r.res = make_res(ST_ALREADY, '0, '0); rows.push_back(r);
        r.known = 0;
        r.req = make_req(MODE_MAP, 48'hFFFF_FFFF_F000, 48'hFFFF_FFFF_F000, 16'd2,
                         3, 7, 3, 1, 1); rows.push_back(r);
        r.req = make_req(MODE_LOOKUP, 48'hFFFF_FFFF_FFFF, 0, 1, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_LOOKUP, 48'h0000_0000_0ABC, 0, 1, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_LOOKUP, 48'h0000_0000_3FFF, 0, 1, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_MAP, 48'h8000_0020_0000, 48'hAAAA_AAAA_A000, 16'd3,
                         2, 5, 2, 0, 1); rows.push_back(r);
        r.req = make_req(MODE_LOOKUP, 48'h8000_0020_1555, 0, 1, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_UNMAP, 48'h1000, 0, 16'd1, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_UNMAP, 48'h1000, 0, 16'd1, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_LOOKUP, 48'h1000, 0, 1, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_UNMAP, 48'h7000_0000_0000, 0, 16'hFFFF, 0, 0, 0, 0, 0);
        rows.push_back(r);
        r.req = make_req(MODE_UNMAP, 48'h2000, 0, 16'hFFFF, 0, 0, 0, 0, 0);
        rows.push_back(r);

        foreach (rows[k])
            send_item(rows[k].req, rows[k].known, rows[k].res);

        // random phases over several pool base settings; back to zero restores
        set_pool_base(36'hF_FFFF_FFFF);
        set_pool_base(36'd0);
        for (i = 0; i < N_RANDOM; i++)
        begin
            if (i == N_RANDOM / 4)
                set_pool_base(36'hF_FFFF_FFFF);
            else if (i == N_RANDOM / 2)
                set_pool_base(36'($urandom()));
            else if (i == 3 * N_RANDOM / 4)
                set_pool_base(36'd0);
            send_item(random_req(), 0, none);
        end

        // run the pool dry with the longest map
        send_item(make_req(MODE_MAP, 48'h4000_0000_0000, 48'h1234_5000, 16'hFFFF,
                           1, 2, 1, 0, 0), 0, none);
        send_item(make_req(MODE_LOOKUP, 48'h4000_0000_0FFF, 0, 1, 0, 0, 0, 0, 0),
                  0, none);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d items and %0d results, %0d of %0d tables allocated",
                 items_sent, results_seen, shadow_used, NPAGES);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
design/flptw_pkg.sv
design/flptw_ctrl.sv
design/flptw_datapath.sv
design/four_level_page_table_walker.sv
tb/tb_four_level_page_table_walker.sv
